FILE: design/ple_pkg.sv
// ple_pkg: shared codes and control types for the positional list engine.
// No dependencies; used by positional_list_engine and ple_cell.
package ple_pkg;

    // Width of the value field on the request port.
    localparam int VALUE_W = 32;

    // Request operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Broadcast command to the cell row; at most one flag set per cycle.
    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
    } cell_cmd_t;

endpackage

FILE: design/positional_list_engine.sv
// positional_list_engine: bounded ordered list addressed by 1-based position.
// Depends on ple_pkg, ple_cell and ple_first_hit.
//
// Usage:
//   Request channel (in_valid / in_stall) carries op, position and value.
//   Result channel (out_valid / out_stall) carries status, found_position
//   and entry_total, exactly one result beat per request beat.
//   Ops: insert at 1..count+1, delete at 1..count, search for first match,
//   update at 1..count. Bad positions, a full list and a failed search
//   report a status code and leave the list untouched.
// Timing:
//   A row of CAPACITY cells holds the entries; every op is at most one broadcast
//   to the row (shift toward the back, shift toward the front, or a local
//   write) and one parallel compare with a priority encoder. A request
//   is done in the cycle it is accepted; its result is registered and
//   shows on the next cycle, and one request can be accepted every
//   cycle while the result side keeps draining.
// Stall: while a result sits in the output register and out_stall is
//   high, in_stall is raised and no request is taken.
// Reset: rst_n clears the entry count (list empty) and the output valid;
//   entry contents are not cleared and are only read after being written.
module positional_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  position,
    input  logic signed [ple_pkg::VALUE_W-1:0] value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [4:0]  found_position,
    output logic [4:0]  entry_total
);

    localparam int IW   = $clog2(CAPACITY);        // entry index
    localparam int CW   = $clog2(CAPACITY + 1);    // entry count
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1; // position vs count compare
    localparam int SW   = ((IW + 1) > 5) ? (IW + 1) : 5;
    localparam int EW   = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    // result payload
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [4:0]    found_position_reg;
    logic [4:0]    found_position_next;
    logic [4:0]    entry_total_reg;
    logic [4:0]    entry_total_next;

    logic                  fire;
    logic [DATA_WIDTH-1:0] wdata;
    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CMPW-1:0]       k_w;
    logic [IW-1:0]         target_idx;
    logic                  ins_pos_ok;
    logic                  rd_pos_ok;
    logic                  is_full;
    ple_pkg::cell_cmd_t    cmd;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   hits;
    logic                  hit_any;
    logic [IW-1:0]         hit_idx;
    logic [SW-1:0]         hit_pos;
    logic [EW-1:0]         total_w;

    // Output register frees up when it is empty or being taken.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    // Only the low DATA_WIDTH bits of the value are kept; a wider DATA_WIDTH zero-extends it.
    generate
        if (DATA_WIDTH <= ple_pkg::VALUE_W)
        begin : g_wdata_trunc
            assign wdata = value[DATA_WIDTH-1:0];
        end
        else
        begin : g_wdata_ext
            assign wdata = {{(DATA_WIDTH - ple_pkg::VALUE_W){1'b0}}, value};
        end
    endgenerate

    // Position checks
    assign pos_w      = CMPW'(position);
    assign cnt_w      = CMPW'(count_reg);
    assign k_w        = pos_w - CMPW'(1);
    assign target_idx = k_w[IW-1:0];
    assign ins_pos_ok = (position != 5'd0) && (pos_w <= (cnt_w + CMPW'(1)));
    assign rd_pos_ok  = (position != 5'd0) && (pos_w <= cnt_w);
    assign is_full    = (count_reg == FULL_COUNT);

    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        status_next = ple_pkg::ST_OK;
        case (op)
            ple_pkg::OP_INSERT:
            begin
                if (!ins_pos_ok)
                    status_next = ple_pkg::ST_BAD_POS;
                else if (is_full)
                    status_next = ple_pkg::ST_FULL;
                else
                begin
                    cmd.ins    = fire;
                    count_next = count_reg + CW'(1);
                end
            end
            ple_pkg::OP_DELETE:
            begin
                if (!rd_pos_ok)
                    status_next = ple_pkg::ST_BAD_POS;
                else
                begin
                    cmd.del    = fire;
                    count_next = count_reg - CW'(1);
                end
            end
            ple_pkg::OP_SEARCH:
            begin
                if (!hit_any)
                    status_next = ple_pkg::ST_NOT_FOUND;
            end
            ple_pkg::OP_UPDATE:
            begin
                if (!rd_pos_ok)
                    status_next = ple_pkg::ST_BAD_POS;
                else
                    cmd.upd = fire;
            end
            default:
            begin
                status_next = ple_pkg::ST_BAD_POS;
            end
        endcase
    end

    // Cell row: cells see their neighbors; wdata feeds cell 0, the last one loops to itself.
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_in;
            logic [DATA_WIDTH-1:0] right_in;

            if (i == 0)
            begin : g_first
                assign left_in = wdata;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[i+1];
            end

            ple_cell #(
                .IDX        (i),
                .IW         (IW),
                .CW         (CW),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .target_idx (target_idx),
                .count      (count_reg),
                .wdata      (wdata),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[i]),
                .match      (hits[i])
            );
        end
    endgenerate

    ple_first_hit #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_first_hit (
        .hits (hits),
        .any  (hit_any),
        .idx  (hit_idx)
    );

    // Result fields
    assign hit_pos = SW'(hit_idx) + SW'(1);
    assign total_w = EW'(count_next);

    always_comb
    begin
        found_position_next = 5'd0;
        if ((op == ple_pkg::OP_SEARCH) && hit_any)
            found_position_next = hit_pos[4:0];
        entry_total_next = total_w[4:0];
        out_valid_next   = fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg         <= status_next;
            found_position_reg <= found_position_next;
            entry_total_reg    <= entry_total_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_position_reg;
    assign entry_total    = entry_total_reg;

endmodule

FILE: design/ple_cell.sv
// ple_cell: one list entry with shift-in from both neighbors and a compare.
// Depends on ple_pkg (cell_cmd_t).
module ple_cell #(
    parameter int IDX        = 0,
    parameter int IW         = 4,
    parameter int CW         = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  ple_pkg::cell_cmd_t    cmd,
    input  logic [IW-1:0]         target_idx,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > target_idx)
                data_next = left_data;
            else if (MY_IDX == target_idx)
                data_next = wdata;
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= target_idx)
                data_next = right_data;
        end
        else if (cmd.upd)
        begin
            if (MY_IDX == target_idx)
                data_next = wdata;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == wdata) && (MY_IDX_C < count);

endmodule

FILE: design/ple_first_hit.sv
// ple_first_hit: priority encoder, lowest set bit of the cell match vector.
// No package dependencies.
module ple_first_hit #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic [N-1:0]  hits,
    output logic          any,
    output logic [IW-1:0] idx
);

    always_comb
    begin
        idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (hits[i])
                idx = IW'(i);
        end
    end

    assign any = |hits;

endmodule
